// ===== hw/rtl/multi_level_job_queue_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the job queue RTL, used by mlq_front.
// ---------------------------------------------------------------------------
`ifndef MULTI_LEVEL_JOB_QUEUE_UNIT_MACROS_SVH
`define MULTI_LEVEL_JOB_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MLQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mlq_pkg.sv =====
// ---------------------------------------------------------------------------
// mlq_pkg
// Types and codes shared by the multi-level job queue modules.
// ---------------------------------------------------------------------------
`default_nettype none

package mlq_pkg;

    // Command codes of an input item.
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    // Status codes of a result item.
    localparam logic [2:0] ST_PUSHED       = 3'd0;
    localparam logic [2:0] ST_REFUSED_LOCK = 3'd1;
    localparam logic [2:0] ST_REFUSED_FULL = 3'd2;
    localparam logic [2:0] ST_POPPED       = 3'd3;
    localparam logic [2:0] ST_POP_EMPTY    = 3'd4;
    localparam logic [2:0] ST_PEEK_FOUND   = 3'd5;
    localparam logic [2:0] ST_PEEK_EMPTY   = 3'd6;

    // Storage access that the back end performs for one item.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ
    } t_op_kind;

    // Control part of an operation handed from front to back.
    typedef struct packed {
        t_op_kind   kind;
        logic [2:0] status;
        logic [1:0] level;
    } t_op_ctl;

    // One input item.
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] job_handle;
        logic [1:0]  level;
        logic [1:0]  fallback_count;
        logic [1:0]  fallback_first;
        logic [1:0]  fallback_second;
        logic [1:0]  fallback_third;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_handle;
        logic [1:0]  out_level;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_level_job_queue_unit.sv =====
// An item passes the operation queue, the back end's register and the result queue in turn.
// Throughput: one item per cycle while results are taken; the single handle memory port
// and the front end's pointer update each handle one item per cycle.
// Reset: synchronous, active low; clears pointers, fill counts, the lock and both queues.
// The handle memory is not cleared and needs no clearing pass; items are taken at once.
// ---------------------------------------------------------------------------
// multi_level_job_queue_unit
// Priority job queue with one FIFO per level, fallback search on pop and
// peek, and a push lock register.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_level_job_queue_unit #(
    parameter int NUM_LEVELS   = 4,
    parameter int QUEUE_DEPTH  = 16,
    parameter int HANDLE_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire mlq_pkg::t_in_item i_item,
    output logic                   empty,
    input  wire logic              pop,
    output mlq_pkg::t_out_item     o_result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              i_cfg_data
);

    localparam int LW   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int IW   = $clog2(QUEUE_DEPTH);
    localparam int AW   = LW + IW;
    localparam int OPW  = $bits(mlq_pkg::t_op_ctl) + AW + 32;
    localparam int RESW = $bits(mlq_pkg::t_out_item);

    logic               acc;
    mlq_pkg::t_op_ctl   fr_ctl;
    logic [AW-1:0]      fr_addr;
    logic [31:0]        fr_data;
    logic [OPW-1:0]     opq_out;
    logic               opq_empty;
    logic               opq_pop;
    mlq_pkg::t_op_ctl   bk_ctl;
    logic [AW-1:0]      bk_addr;
    logic [31:0]        bk_data;
    logic               res_push;
    logic               res_full;
    mlq_pkg::t_out_item res_item;
    logic [RESW-1:0]    resq_out;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign acc       = push && !full;

    // Front end: classify items and update pointers.
    mlq_front #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .i_item     (i_item),
        .o_op_ctl   (fr_ctl),
        .o_op_addr  (fr_addr),
        .o_op_data  (fr_data)
    );

    // Operation queue between front and back.
    mlq_fifo #(
        .WIDTH (OPW),
        .DEPTH (2)
    ) u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_data  ({fr_ctl, fr_addr, fr_data}),
        .o_full  (full),
        .i_pop   (opq_pop),
        .o_data  (opq_out),
        .o_empty (opq_empty)
    );

    assign {bk_ctl, bk_addr, bk_data} = opq_out;

    // Back end: handle memory access and result forming.
    mlq_back #(
        .AW           (AW),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_empty (opq_empty),
        .o_op_pop   (opq_pop),
        .i_op_ctl   (bk_ctl),
        .i_op_addr  (bk_addr),
        .i_op_data  (bk_data),
        .o_res_push (res_push),
        .o_res      (res_item),
        .i_res_full (res_full)
    );

    // Result queue toward the consumer.
    mlq_fifo #(
        .WIDTH (RESW),
        .DEPTH (2)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (resq_out),
        .o_empty (empty)
    );

    assign o_result = mlq_pkg::t_out_item'(resq_out);

endmodule

`default_nettype wire

// ===== hw/rtl/mlq_fifo.sv =====
// ---------------------------------------------------------------------------
// mlq_fifo
// Small register FIFO used for the operation queue and the result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module mlq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Status and handshake qualification.
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mlq_front.sv =====
// ---------------------------------------------------------------------------
// mlq_front
// Accepts items, owns the per-level pointers and fill counts, and turns each
// item into one storage operation with its final status.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multi_level_job_queue_unit_macros.svh"

module mlq_front #(
    parameter int NUM_LEVELS  = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int AW          = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_data,
    input  wire logic              i_acc,
    input  wire mlq_pkg::t_in_item i_item,
    output mlq_pkg::t_op_ctl       o_op_ctl,
    output logic [AW-1:0]          o_op_addr,
    output logic [31:0]            o_op_data
);

    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          r_lock;
    logic [IW-1:0] r_head  [NUM_LEVELS];
    logic [IW-1:0] r_tail  [NUM_LEVELS];
    logic [CW-1:0] r_count [NUM_LEVELS];
    logic [IW-1:0] n_head  [NUM_LEVELS];
    logic [IW-1:0] n_tail  [NUM_LEVELS];
    logic [CW-1:0] n_count [NUM_LEVELS];

    logic [1:0]            order [4];
    logic [3:0]            hit;
    logic [NUM_LEVELS-1:0] not_empty;
    logic [NUM_LEVELS-1:0] is_full;
    logic                  found;
    logic [1:0]            sel_lv;
    logic [LW-1:0]         sel_idx;
    logic [LW-1:0]         push_idx;
    logic                  push_in_range;

    function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] i);
        wrap_next = (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // Search order and per-level occupancy flags.
    always_comb begin
        order[0] = i_item.level;
        order[1] = i_item.fallback_first;
        order[2] = i_item.fallback_second;
        order[3] = i_item.fallback_third;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            not_empty[l] = (r_count[l] != '0);
            is_full[l]   = (r_count[l] == CW'(QUEUE_DEPTH));
        end
        for (int k = 0; k < 4; k++) begin
            hit[k] = (3'(k) <= {1'b0, i_item.fallback_count})
                  && (int'(order[k]) < NUM_LEVELS)
                  && not_empty[LW'(order[k])];
        end
        // The earliest level in the search order wins.
        found  = 1'b0;
        sel_lv = '0;
        for (int k = 3; k >= 0; k--) begin
            if (hit[k]) begin
                found  = 1'b1;
                sel_lv = order[k];
            end
        end
        sel_idx       = LW'(sel_lv);
        push_idx      = LW'(i_item.level);
        push_in_range = (int'(i_item.level) < NUM_LEVELS);
    end

    // Classification and next pointer state.
    always_comb begin
        n_head           = r_head;
        n_tail           = r_tail;
        n_count          = r_count;
        o_op_ctl.kind    = mlq_pkg::OP_NONE;
        o_op_ctl.status  = mlq_pkg::ST_PEEK_EMPTY;
        o_op_ctl.level   = '0;
        o_op_addr        = '0;
        o_op_data        = i_item.job_handle;
        case (i_item.command)
            mlq_pkg::CMD_PUSH: begin
                o_op_ctl.level = i_item.level;
                if (r_lock) begin
                    o_op_ctl.status = mlq_pkg::ST_REFUSED_LOCK;
                end else if (!push_in_range || is_full[push_idx]) begin
                    o_op_ctl.status = mlq_pkg::ST_REFUSED_FULL;
                end else begin
                    o_op_ctl.status = mlq_pkg::ST_PUSHED;
                    o_op_ctl.kind   = mlq_pkg::OP_WRITE;
                    o_op_addr       = {push_idx, r_tail[push_idx]};
                    if (i_acc) begin
                        n_tail[push_idx]  = wrap_next(r_tail[push_idx]);
                        n_count[push_idx] = r_count[push_idx] + 1'b1;
                    end
                end
            end
            mlq_pkg::CMD_POP: begin
                if (found) begin
                    o_op_ctl.status = mlq_pkg::ST_POPPED;
                    o_op_ctl.kind   = mlq_pkg::OP_READ;
                    o_op_ctl.level  = sel_lv;
                    o_op_addr       = {sel_idx, r_head[sel_idx]};
                    if (i_acc) begin
                        n_head[sel_idx]  = wrap_next(r_head[sel_idx]);
                        n_count[sel_idx] = r_count[sel_idx] - 1'b1;
                    end
                end else begin
                    o_op_ctl.status = mlq_pkg::ST_POP_EMPTY;
                end
            end
            mlq_pkg::CMD_PEEK: begin
                if (found) begin
                    o_op_ctl.status = mlq_pkg::ST_PEEK_FOUND;
                    o_op_ctl.kind   = mlq_pkg::OP_READ;
                    o_op_ctl.level  = sel_lv;
                    o_op_addr       = {sel_idx, r_head[sel_idx]};
                end
            end
            default: begin
                o_op_ctl.status = mlq_pkg::ST_PEEK_EMPTY;
            end
        endcase
    end

    // Lock register, pointers and fill counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_lock <= i_cfg_data;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // A write is only issued for an unlocked push.
    `MLQ_ASSERT_IMPL(a_write_unlocked, i_clk, i_rst_n,
        i_acc && (o_op_ctl.kind == mlq_pkg::OP_WRITE), !r_lock, "write issued while locked")
    // Writes always carry the pushed status.
    `MLQ_ASSERT_IMPL(a_write_status, i_clk, i_rst_n,
        o_op_ctl.kind == mlq_pkg::OP_WRITE, o_op_ctl.status == mlq_pkg::ST_PUSHED,
        "write without pushed status")
    // Reads only come from a successful pop or peek.
    `MLQ_ASSERT_IMPL(a_read_status, i_clk, i_rst_n,
        o_op_ctl.kind == mlq_pkg::OP_READ,
        (o_op_ctl.status == mlq_pkg::ST_POPPED) || (o_op_ctl.status == mlq_pkg::ST_PEEK_FOUND),
        "read without a found status")
    // A locked push leaves the preferred level's count untouched.
    `MLQ_ASSERT_IMPL(a_lock_holds, i_clk, i_rst_n,
        i_acc && r_lock && (i_item.command == mlq_pkg::CMD_PUSH) && push_in_range,
        n_count[push_idx] == r_count[push_idx], "locked push changed a fill count")

endmodule

`default_nettype wire

// ===== hw/rtl/mlq_back.sv =====
// ---------------------------------------------------------------------------
// mlq_back
// Carries out storage operations on the handle memory and forms the result
// items, one operation per cycle unless the result queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module mlq_back #(
    parameter int AW           = 6,
    parameter int HANDLE_WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_op_empty,
    output logic                  o_op_pop,
    input  wire mlq_pkg::t_op_ctl i_op_ctl,
    input  wire logic [AW-1:0]    i_op_addr,
    input  wire logic [31:0]      i_op_data,
    output logic                  o_res_push,
    output mlq_pkg::t_out_item    o_res,
    input  wire logic             i_res_full
);

    localparam int SW = (HANDLE_WIDTH < 32) ? HANDLE_WIDTH : 32;
    localparam int MD = 1 << AW;

    logic [SW-1:0]    r_mem [MD];
    logic [SW-1:0]    r_rdata;
    logic             r_valid;
    mlq_pkg::t_op_ctl r_ctl;

    // Take a new operation when the stage is free or drains this cycle.
    assign o_op_pop   = !i_op_empty && (!r_valid || !i_res_full);
    assign o_res_push = r_valid && !i_res_full;

    // Handle memory with one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (o_op_pop && (i_op_ctl.kind == mlq_pkg::OP_WRITE)) begin
            r_mem[i_op_addr] <= i_op_data[SW-1:0];
        end
        if (o_op_pop && (i_op_ctl.kind == mlq_pkg::OP_READ)) begin
            r_rdata <= r_mem[i_op_addr];
        end
        if (o_op_pop) begin
            r_ctl <= i_op_ctl;
        end
    end

    // Stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_op_pop) begin
            r_valid <= 1'b1;
        end else if (o_res_push) begin
            r_valid <= 1'b0;
        end
    end

    // Result item.
    always_comb begin
        o_res.status     = r_ctl.status;
        o_res.out_level  = r_ctl.level;
        o_res.out_handle = (r_ctl.kind == mlq_pkg::OP_READ) ? 32'(r_rdata) : '0;
    end

endmodule

`default_nettype wire

// ===== tb/multi_level_job_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_level_job_queue_unit_tb
// Drives push, pop and peek commands into the priority job queue. The
// commands go through directed corner cases and then long random bursts. A
// behavioral copy of the per-level FIFOs predicts every result item, and the
// testbench compares each popped result field by field. The push lock
// register is toggled between phases, and both handshakes are stalled at
// random.
// ---------------------------------------------------------------------------

module multi_level_job_queue_unit_tb;

    localparam int          LEVEL_COUNT   = 4;
    localparam int          LEVEL_DEPTH   = 16;
    localparam int          LONG_STALL    = 400;
    localparam logic [1:0]  CMD_IGNORED   = 2'd3;
    localparam logic [31:0] HANDLE_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] HANDLE_ZERO   = 32'h0000_0000;

    // Behavioral copy of the level FIFOs and the lock. It keeps the results
    // that are still owed by the block.
    class job_queue_model;
        logic [31:0]          handles [LEVEL_COUNT][LEVEL_DEPTH];
        int unsigned          head_pos [LEVEL_COUNT];
        int unsigned          tail_pos [LEVEL_COUNT];
        int unsigned          fill [LEVEL_COUNT];
        bit                   lock;
        mlq_pkg::t_out_item   expected_results [$];
        int                   errors;

        function void set_lock(logic value);
            lock = value;
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction

        // Works out the result of one accepted item and updates the FIFOs.
        function void accept_command(mlq_pkg::t_in_item cmd_item);
            mlq_pkg::t_out_item res;
            logic [1:0]         search [4];
            int                 k;
            int                 sel;
            bit                 served;
            res    = '0;
            served = 1'b0;
            search[0] = cmd_item.level;
            search[1] = cmd_item.fallback_first;
            search[2] = cmd_item.fallback_second;
            search[3] = cmd_item.fallback_third;
            case (cmd_item.command)
                mlq_pkg::CMD_PUSH: begin
                    res.out_level = cmd_item.level;
                    sel = int'(cmd_item.level);
                    // The lock wins over a full level.
                    if (lock) begin
                        res.status = mlq_pkg::ST_REFUSED_LOCK;
                    end else if (sel >= LEVEL_COUNT || fill[sel] >= LEVEL_DEPTH) begin
                        res.status = mlq_pkg::ST_REFUSED_FULL;
                    end else begin
                        handles[sel][tail_pos[sel]] = cmd_item.job_handle;
                        tail_pos[sel] = (tail_pos[sel] + 1) % LEVEL_DEPTH;
                        fill[sel] += 1;
                        res.status = mlq_pkg::ST_PUSHED;
                    end
                end
                mlq_pkg::CMD_POP, mlq_pkg::CMD_PEEK: begin
                    res.status = (cmd_item.command == mlq_pkg::CMD_POP) ?
                                 mlq_pkg::ST_POP_EMPTY : mlq_pkg::ST_PEEK_EMPTY;
                    // Preferred level first, then the valid fallback levels in order.
                    for (k = 0; k <= cmd_item.fallback_count; k++) begin
                        sel = int'(search[k]);
                        if (!served && sel < LEVEL_COUNT && fill[sel] != 0) begin
                            served = 1'b1;
                            res.out_handle = handles[sel][head_pos[sel]];
                            res.out_level  = search[k];
                            if (cmd_item.command == mlq_pkg::CMD_POP) begin
                                head_pos[sel] = (head_pos[sel] + 1) % LEVEL_DEPTH;
                                fill[sel] -= 1;
                                res.status = mlq_pkg::ST_POPPED;
                            end else begin
                                res.status = mlq_pkg::ST_PEEK_FOUND;
                            end
                        end
                    end
                end
                default: begin
                    res.status = mlq_pkg::ST_PEEK_EMPTY;
                end
            endcase
            expected_results = {expected_results, res};
        endfunction

        // Compares one result item with the oldest expected one.
        function void check_result(mlq_pkg::t_out_item got);
            mlq_pkg::t_out_item want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual status %0d handle %h level %0d",
                         $time, got.status, got.out_handle, got.out_level);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.out_handle !== want.out_handle) begin
                $display("%0t: out_handle mismatch, expected %h, actual %h",
                         $time, want.out_handle, got.out_handle);
                errors++;
            end
            if (got.out_level !== want.out_level) begin
                $display("%0t: out_level mismatch, expected %0d, actual %0d",
                         $time, want.out_level, got.out_level);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    mlq_pkg::t_in_item  i_item = '0;
    logic               empty;
    logic               pop = 1'b0;
    mlq_pkg::t_out_item o_result;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               i_cfg_data = 1'b0;

    int         send_idle_pct = 23;
    int         recv_idle_pct = 60;
    logic       long_stall_req = 1'b0;

    job_queue_model queue_model = new;

    multi_level_job_queue_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watch both handshakes and the register write at every rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                queue_model.check_result(o_result);
            end
            if (cfg_valid && cfg_ready) begin
                queue_model.set_lock(i_cfg_data);
            end
            if (push && !full) begin
                queue_model.accept_command(i_item);
            end
        end
    end

    // The result side pops at random, and holds off once for a long stretch on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_stall_req) begin
                long_stall_req <= 1'b0;
                pop <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Hard limit on the run.
    initial begin
        #2_000_000;
        $display("multi_level_job_queue_unit test failed");
        $finish;
    end

    function automatic mlq_pkg::t_in_item make_item(logic [1:0] command, logic [31:0] handle,
                                                    logic [1:0] level, logic [1:0] count,
                                                    logic [1:0] first, logic [1:0] second,
                                                    logic [1:0] third);
        mlq_pkg::t_in_item it;
        it.command         = command;
        it.job_handle      = handle;
        it.level           = level;
        it.fallback_count  = count;
        it.fallback_first  = first;
        it.fallback_second = second;
        it.fallback_third  = third;
        return it;
    endfunction

    // Random command. Pushes lean toward one hot level so that levels fill up.
    function automatic mlq_pkg::t_in_item random_command(int push_pct, logic [1:0] hot_level);
        mlq_pkg::t_in_item it;
        int                roll;
        it = make_item(mlq_pkg::CMD_POP, $urandom, 2'($urandom_range(0, 3)),
                       2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            it.job_handle = HANDLE_ZERO;
        end else if (roll == 1) begin
            it.job_handle = HANDLE_ONES;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            it.command = CMD_IGNORED;
        end else if (roll < 3 + push_pct) begin
            it.command = mlq_pkg::CMD_PUSH;
            if ($urandom_range(0, 1) == 1) begin
                it.level = hot_level;
            end
        end else if ($urandom_range(0, 9) < 7) begin
            it.command = mlq_pkg::CMD_POP;
        end else begin
            it.command = mlq_pkg::CMD_PEEK;
        end
        return it;
    endfunction

    // Offer one item, with random gaps before it, and wait until it is taken.
    task automatic send_item(mlq_pkg::t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
    endtask

    // Stop offering items and wait until every result has come out.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (queue_model.pending_count() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_lock(logic value);
        cfg_valid  <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random bursts; the push share changes every 40 items.
    task automatic run_random(int count);
        int         i;
        int         push_pct;
        logic [1:0] hot_level;
        push_pct  = 50;
        hot_level = 2'd0;
        for (i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
                hot_level = 2'($urandom_range(0, 3));
            end
            send_item(random_command(push_pct, hot_level));
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corner cases with the lock open.
        write_lock(1'b0);
        send_item(make_item(mlq_pkg::CMD_POP, HANDLE_ONES, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0));
        send_item(make_item(mlq_pkg::CMD_PEEK, HANDLE_ONES, 2'd1, 2'd3, 2'd0, 2'd2, 2'd3));
        send_item(make_item(CMD_IGNORED, HANDLE_ONES, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3));
        send_item(make_item(mlq_pkg::CMD_PUSH, HANDLE_ZERO, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0));
        send_item(make_item(mlq_pkg::CMD_PUSH, HANDLE_ONES, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3));
        send_item(make_item(mlq_pkg::CMD_PUSH, 32'hA5A5_5A5A, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0));
        // A peek must search the fallback levels, not the preferred one again.
        send_item(make_item(mlq_pkg::CMD_PEEK, HANDLE_ZERO, 2'd2, 2'd1, 2'd3, 2'd0, 2'd0));
        // Repeated fallback levels are simply tried again.
        send_item(make_item(mlq_pkg::CMD_PEEK, HANDLE_ZERO, 2'd2, 2'd3, 2'd2, 2'd2, 2'd1));
        send_item(make_item(mlq_pkg::CMD_POP, HANDLE_ZERO, 2'd2, 2'd2, 2'd0, 2'd3, 2'd1));
        send_item(make_item(mlq_pkg::CMD_POP, HANDLE_ZERO, 2'd3, 2'd0, 2'd1, 2'd1, 2'd1));
        send_item(make_item(mlq_pkg::CMD_POP, HANDLE_ZERO, 2'd0, 2'd3, 2'd0, 2'd3, 2'd1));
        send_item(make_item(mlq_pkg::CMD_POP, HANDLE_ZERO, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3));
        send_item(make_item(mlq_pkg::CMD_PEEK, HANDLE_ZERO, 2'd0, 2'd0, 2'd1, 2'd2, 2'd3));
        wait_idle();

        // Directed items under the push lock.
        write_lock(1'b1);
        send_item(make_item(mlq_pkg::CMD_PUSH, HANDLE_ONES, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0));
        send_item(make_item(mlq_pkg::CMD_PUSH, 32'h1234_5678, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3));
        send_item(make_item(mlq_pkg::CMD_POP, HANDLE_ZERO, 2'd1, 2'd3, 2'd2, 2'd3, 2'd0));
        wait_idle();
        write_lock(1'b0);

        // Sender idles rarely, receiver often, with one long receiver hold-off.
        long_stall_req <= 1'b1;
        run_random(650);
        wait_idle();

        // Random traffic against a locked queue, then unlock again.
        write_lock(1'b1);
        run_random(120);
        wait_idle();
        write_lock(1'b0);

        // Sender idles often, receiver rarely.
        send_idle_pct = 60;
        recv_idle_pct <= 23;
        run_random(600);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_random(580);
        wait_idle();

        if (queue_model.errors == 0 && queue_model.pending_count() == 0) begin
            $display("multi_level_job_queue_unit test passed");
        end else begin
            $display("multi_level_job_queue_unit test failed");
        end
        $finish;
    end

endmodule
